// ===== design/aopc_pkg.sv =====
// Shared constants and controller/datapath interface types for the audio pacing block.
package aopc_pkg;

  localparam int BUFFER_DEPTH  = 1536;
  localparam int FILTER_LEAD   = 16;
  localparam int WINDOW_BLOCKS = 15;
  localparam int MAX_REPEATS   = 10;
  localparam int DROP_WINDOWS  = 10;
  localparam int FRAMES_MAX    = 4095;
  localparam int LEAD_OFFSET   = FILTER_LEAD - 8;

  localparam int LEVEL_W  = 11;
  localparam int STEP_W   = 36;
  localparam int BYTES_W  = 18;
  localparam int RINC_W   = 20;
  localparam int FRAMES_W = 12;
  localparam int WRITES_W = 4;
  localparam int POS_W    = 48;
  localparam int RFRAC_W  = 16;
  localparam int CNT4_W   = 4;

  // limit = {level + lead offset, 32 ones}; level + offset stays below 2^11
  localparam int LIM_W      = LEVEL_W + 32;
  localparam int NPOS_W     = LIM_W + 1;
  localparam int DIV_STEPS  = LIM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESAMPLE_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_EXTRA    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INC      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PENDING_MODE    = 3'd4;

  localparam logic [STEP_W-1:0]  RST_RESAMPLE_STEP = 36'd5719494464;
  localparam logic [BYTES_W-1:0] RST_TARGET_MIN    = 18'd19200;
  localparam logic [BYTES_W-1:0] RST_TARGET_EXTRA  = 18'd38400;
  localparam logic [RINC_W-1:0]  RST_REPEAT_INC    = 20'd65536;

  typedef struct packed {
    logic accept;    // item taken from input channel
    logic load;      // compute limit, start divider
    logic div_step;  // one divider iteration
    logic pos;       // frame count and new position
    logic pace;      // level shift, window tracking, load output
  } cmd_t;

  typedef struct packed {
    logic pos_ok;    // position within usable data (valid in load)
    logic out_busy;  // output register holds an item not yet taken
  } sts_t;

endpackage

// ===== design/aopc_div.sv =====
// Restoring serial divider: one quotient bit per iteration, remainder kept.
module aopc_div (
  input  logic                              clk,
  input  logic                              start,
  input  logic                              step_en,
  input  logic [aopc_pkg::LIM_W-1:0]        dvd,
  input  logic [aopc_pkg::STEP_W-1:0]       dvs,
  output logic [aopc_pkg::LIM_W-1:0]        quot,
  output logic [aopc_pkg::STEP_W-1:0]       rem
);

  logic [aopc_pkg::LIM_W-1:0]  dq_r, dq_nxt;
  logic [aopc_pkg::STEP_W-1:0] rem_r, rem_nxt;
  logic [aopc_pkg::STEP_W-1:0] dvs_r;
  logic [aopc_pkg::STEP_W:0]   trial;
  logic [aopc_pkg::STEP_W:0]   diff;
  logic                        qbit;

  always_comb begin
    trial   = {rem_r, dq_r[aopc_pkg::LIM_W-1]};
    diff    = trial - {1'b0, dvs_r};
    qbit    = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? diff[aopc_pkg::STEP_W-1:0] : trial[aopc_pkg::STEP_W-1:0];
    dq_nxt  = {dq_r[aopc_pkg::LIM_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dvd;
      rem_r <= '0;
      dvs_r <= dvs;
    end else if (step_en) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = dq_r;
  assign rem  = rem_r;

endmodule

// ===== design/aopc_ctrl.sv =====
// Sequencer: accept, load, divide, position update, pacing/output.
module aopc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  aopc_pkg::sts_t    sts,
  output aopc_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_DIV  = 5'b00100,
    S_POS  = 5'b01000,
    S_PACE = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [aopc_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.pos_ok ? S_DIV : S_POS;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == aopc_pkg::DIV_CNT_W'(aopc_pkg::DIV_STEPS - 1)) state_nxt = S_POS;
      end
      S_POS: begin
        cmd.pos   = 1'b1;
        state_nxt = S_PACE;
      end
      S_PACE: begin
        if (!sts.out_busy) begin
          cmd.pace  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== design/aopc_dp.sv =====
// Datapath: configuration, buffer level, resample position, window tracking, output register.
module aopc_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  aopc_pkg::cmd_t                        cmd,
  output aopc_pkg::sts_t                        sts,
  input  logic                                  cfg_we,
  input  logic [aopc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aopc_pkg::STEP_W-1:0]           cfg_wdata,
  input  logic [aopc_pkg::LEVEL_W-1:0]          in_sample_count,
  input  logic [aopc_pkg::BYTES_W-1:0]          in_sink_level_bytes,
  input  logic                                  in_sink_underflow,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [aopc_pkg::FRAMES_W-1:0]         out_frames_out,
  output logic [aopc_pkg::WRITES_W-1:0]         out_block_writes,
  output logic                                  out_block_dropped,
  output logic                                  out_underflow_write,
  output logic                                  out_overflow_seen,
  output logic [aopc_pkg::LEVEL_W-1:0]          out_buffer_level
);

  localparam int LW = aopc_pkg::LEVEL_W;
  localparam int BW = aopc_pkg::BYTES_W;
  localparam int FW = aopc_pkg::FRAMES_W;

  // configuration
  logic [aopc_pkg::STEP_W-1:0] step_r;
  logic [BW-1:0]               tmin_r, textra_r;
  logic [aopc_pkg::RINC_W-1:0] rinc_r;
  logic                        mode_r;

  // state
  logic [LW-1:0]                sl_r, sl_nxt;
  logic [aopc_pkg::POS_W-1:0]   pos_r;
  logic [aopc_pkg::CNT4_W-1:0]  wc_r, wc_nxt;
  logic [BW-1:0]                wmin_r, wmin_nxt;
  logic [BW-1:0]                wmax_r, wmax_nxt;
  logic                         wuf_r, wuf_nxt;
  logic [aopc_pkg::CNT4_W-1:0]  ds_r, ds_nxt;
  logic [aopc_pkg::RFRAC_W-1:0] rf_r, rf_nxt;

  // item payload
  logic [BW-1:0]                bytes_r;
  logic                         uf_r;
  logic                         ok_r;
  logic [aopc_pkg::LIM_W-1:0]   limit_r;
  logic [FW-1:0]                frames_r;
  logic [aopc_pkg::NPOS_W-1:0]  npos_r;

  // output register
  logic                         out_valid_r;
  logic [FW-1:0]                o_frames_r;
  logic [aopc_pkg::WRITES_W-1:0] o_writes_r;
  logic                         o_drop_r, o_uw_r, o_over_r;
  logic [LW-1:0]                o_level_r;

  // accept
  logic [LW-1:0] free_space, cnt_clamped;

  always_comb begin
    free_space  = LW'(aopc_pkg::BUFFER_DEPTH) - sl_r;
    cnt_clamped = (in_sample_count > free_space) ? free_space : in_sample_count;
  end

  // load: limit and divider operands
  logic [aopc_pkg::LIM_W-1:0]  limit;
  logic [aopc_pkg::LIM_W-1:0]  dvd;
  logic [aopc_pkg::STEP_W-1:0] step_eff;
  logic                        pos_ok;

  always_comb begin
    limit    = {sl_r + LW'(aopc_pkg::LEAD_OFFSET), 32'hFFFF_FFFF};
    pos_ok   = ({(aopc_pkg::POS_W - aopc_pkg::LIM_W)'(0), limit} >= pos_r);
    dvd      = limit - pos_r[aopc_pkg::LIM_W-1:0];
    step_eff = (step_r == '0) ? aopc_pkg::STEP_W'(1) : step_r;
  end

  logic [aopc_pkg::LIM_W-1:0]  quot;
  logic [aopc_pkg::STEP_W-1:0] rem;

  aopc_div u_div (
    .clk     (clk),
    .start   (cmd.load),
    .step_en (cmd.div_step),
    .dvd     (dvd),
    .dvs     (step_eff),
    .quot    (quot),
    .rem     (rem)
  );

  // pos stage: pos + step*(q+1) equals limit - rem + step
  logic [FW-1:0]               frames_c;
  logic [aopc_pkg::NPOS_W-1:0] npos_c;

  always_comb begin
    if (!ok_r)
      frames_c = '0;
    else if (quot >= aopc_pkg::LIM_W'(aopc_pkg::FRAMES_MAX))
      frames_c = FW'(aopc_pkg::FRAMES_MAX);
    else
      frames_c = quot[FW-1:0] + FW'(1);
    npos_c = {1'b0, limit_r}
           + {(aopc_pkg::NPOS_W - aopc_pkg::STEP_W)'(0), step_eff}
           - {(aopc_pkg::NPOS_W - aopc_pkg::STEP_W)'(0), rem};
  end

  // pace stage
  logic [FW-1:0]               shift_raw, shift_c;
  logic [LW-1:0]               sl_fin;
  logic [aopc_pkg::POS_W-1:0]  pos_fin;
  logic [BW-1:0]               wmin_t, wmax_t;
  logic [BW+1:0]               adj_min, adj_extra;
  logic [BW+2:0]               drop_thr, upper;
  logic [aopc_pkg::CNT4_W-1:0] wc_inc, ds_inc;
  logic                        win_end, try_drop, under, drop, over;
  logic [aopc_pkg::RINC_W:0]   acc;
  logic [4:0]                  n_raw;
  logic [aopc_pkg::WRITES_W-1:0] n_rep, writes;

  always_comb begin
    shift_raw = npos_r[aopc_pkg::NPOS_W-1:32];
    shift_c   = (shift_raw > {1'b0, sl_r}) ? {1'b0, sl_r} : shift_raw;
    sl_fin    = ok_r ? (sl_r - shift_c[LW-1:0]) : sl_r;
    pos_fin   = {(aopc_pkg::POS_W - aopc_pkg::NPOS_W)'(0),
                 npos_r[aopc_pkg::NPOS_W-1:32] - shift_c, npos_r[31:0]};

    wmin_t = (wmin_r > bytes_r) ? bytes_r : wmin_r;
    wmax_t = (wmax_r < bytes_r) ? bytes_r : wmax_r;

    adj_min   = {2'b00, tmin_r};
    adj_extra = {2'b00, textra_r};
    if (mode_r) begin
      adj_min   = adj_min   + {6'b0, frames_r, 2'b00};
      adj_extra = adj_extra + {6'b0, frames_r, 2'b00};
    end
    drop_thr = {1'b0, adj_min} + {6'b0, frames_r, 3'b000};
    upper    = {1'b0, adj_min} + {1'b0, adj_extra};

    wc_inc   = wc_r + 1'b1;
    ds_inc   = ds_r + 1'b1;
    win_end  = (wc_inc >= aopc_pkg::CNT4_W'(aopc_pkg::WINDOW_BLOCKS));
    try_drop = !wuf_r && ({3'b000, wmin_t} > drop_thr);

    wc_nxt   = wc_inc;
    wmin_nxt = wmin_t;
    wmax_nxt = wmax_t;
    wuf_nxt  = wuf_r;
    ds_nxt   = ds_r;
    rf_nxt   = rf_r;
    drop     = 1'b0;
    over     = 1'b0;
    writes   = '0;

    if (win_end) begin
      wc_nxt = '0;
      if (try_drop) begin
        if (ds_inc >= aopc_pkg::CNT4_W'(aopc_pkg::DROP_WINDOWS)) begin
          ds_nxt = '0;
          drop   = 1'b1;
        end else begin
          ds_nxt = ds_inc;
        end
      end else begin
        ds_nxt = '0;
      end
      wmin_nxt = '1;
      wmax_nxt = '0;
      wuf_nxt  = 1'b0;
    end

    under = ({2'b00, bytes_r} < adj_min) || uf_r;
    if (under) begin
      wuf_nxt = 1'b1;
      writes  = aopc_pkg::WRITES_W'(1);
      ds_nxt  = '0;
      drop    = 1'b0;
    end

    acc   = {5'b0, rf_r} + {1'b0, rinc_r};
    n_raw = acc[aopc_pkg::RINC_W:16];
    n_rep = (n_raw > 5'(aopc_pkg::MAX_REPEATS)) ? aopc_pkg::WRITES_W'(aopc_pkg::MAX_REPEATS)
                                                : n_raw[aopc_pkg::WRITES_W-1:0];
    if (!drop) begin
      if ({3'b000, bytes_r} < upper) begin
        rf_nxt = acc[15:0];
        writes = writes + n_rep;
      end else begin
        over = 1'b1;
      end
    end
  end

  always_comb begin
    sl_nxt = sl_r;
    if (cmd.accept)
      sl_nxt = sl_r + cnt_clamped;
    else if (cmd.pace)
      sl_nxt = sl_fin;
  end

  assign sts.pos_ok   = pos_ok;
  assign sts.out_busy = out_valid_r && out_stall;

  // configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= aopc_pkg::RST_RESAMPLE_STEP;
      tmin_r   <= aopc_pkg::RST_TARGET_MIN;
      textra_r <= aopc_pkg::RST_TARGET_EXTRA;
      rinc_r   <= aopc_pkg::RST_REPEAT_INC;
      mode_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aopc_pkg::CFG_RESAMPLE_STEP: step_r   <= cfg_wdata;
        aopc_pkg::CFG_TARGET_MIN:    tmin_r   <= cfg_wdata[BW-1:0];
        aopc_pkg::CFG_TARGET_EXTRA:  textra_r <= cfg_wdata[BW-1:0];
        aopc_pkg::CFG_REPEAT_INC:    rinc_r   <= cfg_wdata[aopc_pkg::RINC_W-1:0];
        aopc_pkg::CFG_PENDING_MODE:  mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sl_r        <= '0;
      pos_r       <= '0;
      wc_r        <= '0;
      wmin_r      <= '1;
      wmax_r      <= '0;
      wuf_r       <= 1'b0;
      ds_r        <= '0;
      rf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sl_r <= sl_nxt;
      if (cmd.pace) begin
        if (ok_r) pos_r <= pos_fin;
        wc_r   <= wc_nxt;
        wmin_r <= wmin_nxt;
        wmax_r <= wmax_nxt;
        wuf_r  <= wuf_nxt;
        ds_r   <= ds_nxt;
        rf_r   <= rf_nxt;
      end
      if (cmd.pace)
        out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bytes_r <= in_sink_level_bytes;
      uf_r    <= in_sink_underflow;
    end
    if (cmd.load) begin
      ok_r    <= pos_ok;
      limit_r <= limit;
    end
    if (cmd.pos) begin
      frames_r <= frames_c;
      npos_r   <= npos_c;
    end
    if (cmd.pace) begin
      o_frames_r <= frames_r;
      o_writes_r <= writes;
      o_drop_r   <= drop;
      o_uw_r     <= under;
      o_over_r   <= over;
      o_level_r  <= sl_fin;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frames_out      = o_frames_r;
  assign out_block_writes    = o_writes_r;
  assign out_block_dropped   = o_drop_r;
  assign out_underflow_write = o_uw_r;
  assign out_overflow_seen   = o_over_r;
  assign out_buffer_level    = o_level_r;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sl_r <= LW'(aopc_pkg::BUFFER_DEPTH))
    else $error("source level beyond buffer depth");

  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r < aopc_pkg::CNT4_W'(aopc_pkg::WINDOW_BLOCKS) &&
    ds_r < aopc_pkg::CNT4_W'(aopc_pkg::DROP_WINDOWS))
    else $error("window or drop counter out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pace |-> !(out_valid_r && out_stall))
    else $error("output register overwritten while stalled");

  a_pace_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pace |=> out_valid_r)
    else $error("paced item not presented");

  a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(o_drop_r && (o_uw_r || o_over_r)) &&
                    o_writes_r <= aopc_pkg::WRITES_W'(aopc_pkg::MAX_REPEATS + 1))
    else $error("inconsistent result flags");
`endif

endmodule

// ===== design/audio_output_pacing_control.sv =====
// Audio output pacing control: top level joining sequencer and datapath.
// Usage:
//   Input channel (in_valid/in_stall): one item per audio block with the new
//   sample count, the sink's measured fill in bytes and its underflow flag.
//   Result channel (out_valid/out_stall): one item per input item with the
//   resampled frame count, write count, drop/underflow/overflow flags and the
//   source level left after the consumed samples are shifted out.
//   Configuration (cfg_we/cfg_index/cfg_wdata): write only while idle.
// Timing: an item runs load, a 43-step serial divide (one quotient bit per
//   cycle), a position step and a pacing step; the next item is accepted
//   only after the pacing step, result valid after the last of them. When the
//   position lies past the data the divide is skipped.
// Stall: a finished result waits in the output register; the next item is
//   taken meanwhile and its pacing step holds until the register is free.
// Reset (rst_n low, synchronous): registers take their default values, the
//   buffer is empty, position zero, window minimum all ones, no result valid.
module audio_output_pacing_control (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [aopc_pkg::LEVEL_W-1:0]      in_sample_count,
  input  logic [aopc_pkg::BYTES_W-1:0]      in_sink_level_bytes,
  input  logic                              in_sink_underflow,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [aopc_pkg::FRAMES_W-1:0]     out_frames_out,
  output logic [aopc_pkg::WRITES_W-1:0]     out_block_writes,
  output logic                              out_block_dropped,
  output logic                              out_underflow_write,
  output logic                              out_overflow_seen,
  output logic [aopc_pkg::LEVEL_W-1:0]      out_buffer_level,
  input  logic                              cfg_we,
  input  logic [aopc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aopc_pkg::STEP_W-1:0]       cfg_wdata
);

  aopc_pkg::cmd_t cmd;
  aopc_pkg::sts_t sts;

  aopc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  aopc_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_sample_count     (in_sample_count),
    .in_sink_level_bytes (in_sink_level_bytes),
    .in_sink_underflow   (in_sink_underflow),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frames_out      (out_frames_out),
    .out_block_writes    (out_block_writes),
    .out_block_dropped   (out_block_dropped),
    .out_underflow_write (out_underflow_write),
    .out_overflow_seen   (out_overflow_seen),
    .out_buffer_level    (out_buffer_level)
  );

endmodule
